[hw/rtl/dual_pump_hysteresis_controller_unit_assert.svh]
// Assertion macros for the dual pump controller.
// Used by the top level only; needs clk and rst_n in the including scope.
`ifndef DUAL_PUMP_HYSTERESIS_CONTROLLER_UNIT_ASSERT_SVH
`define DUAL_PUMP_HYSTERESIS_CONTROLLER_UNIT_ASSERT_SVH

// same-cycle implication
`define DPHC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dphc assertion failed");

// next-cycle implication
`define DPHC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dphc assertion failed");

`endif

[hw/rtl/dphc_pkg.sv]
// Shared types, register indexes and the per-pump step function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dphc_pkg;

  localparam int LevelW = 12;
  localparam int TimeW  = 32;
  localparam int CfgIdxW = 3;

  typedef logic [LevelW-1:0] level_t;
  typedef logic [TimeW-1:0]  tick_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_P1_ON  = 3'd0;
  localparam cfg_idx_t CFG_P1_OFF = 3'd1;
  localparam cfg_idx_t CFG_P2_ON  = 3'd2;
  localparam cfg_idx_t CFG_P2_OFF = 3'd3;
  localparam cfg_idx_t CFG_MIN_OFF = 3'd4;
  localparam cfg_idx_t CFG_MAX_ON  = 3'd5;
  localparam cfg_idx_t CFG_SHARE   = 3'd6;

  typedef struct packed {
    logic  running;
    tick_t start_time;
    tick_t stop_time;
  } pump_state_t;

  // One check of one pump. The stop test sees the state after the start test;
  // on a fresh start the elapsed run time is zero, so both elapsed values are
  // computed in parallel from the old state.
  function automatic pump_state_t pump_step(
    input pump_state_t cur,
    input tick_t       now,
    input level_t      level,
    input level_t      on_level,
    input level_t      off_level,
    input tick_t       min_off,
    input tick_t       max_on
  );
    pump_state_t nxt;
    tick_t       since_stop;
    tick_t       since_start;
    logic        start_ok;
    logic        fresh;
    logic        run_mid;
    logic        stop_ok;
    nxt         = cur;
    since_stop  = now - cur.stop_time;
    start_ok    = (level > on_level) && (since_stop >= min_off);
    fresh       = start_ok && !cur.running;
    run_mid     = cur.running || start_ok;
    since_start = fresh ? '0 : (now - cur.start_time);
    stop_ok     = (level < off_level) || (since_start >= max_on);
    if (fresh) begin
      nxt.start_time = now;
    end
    if (stop_ok && run_mid) begin
      nxt.stop_time = now;
    end
    nxt.running = run_mid && !stop_ok;
    return nxt;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/dphc_if.sv]
// Valid/ready channel interfaces: check input, pump result, config write.
// Depends on dphc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface dphc_in_if;
  logic             valid;
  logic             ready;
  dphc_pkg::tick_t  now_ms;
  dphc_pkg::level_t moisture_a;
  dphc_pkg::level_t moisture_b;
  modport source (output valid, output now_ms, output moisture_a, output moisture_b,
                  input ready);
  modport sink   (input valid, input now_ms, input moisture_a, input moisture_b,
                  output ready);
endinterface

interface dphc_out_if;
  logic valid;
  logic ready;
  logic pump_a_drive;
  logic pump_b_drive;
  modport source (output valid, output pump_a_drive, output pump_b_drive, input ready);
  modport sink   (input valid, input pump_a_drive, input pump_b_drive, output ready);
endinterface

interface dphc_cfg_if;
  logic               valid;
  logic               ready;
  dphc_pkg::cfg_idx_t index;
  dphc_pkg::tick_t    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/dual_pump_hysteresis_controller_unit.sv]
// Dual pump hysteresis controller, top level.
// Depends on dphc_pkg, dphc_if.sv and the assertion header.
//
//  channel  dir  beat payload                       handshake
//  in_ch    in   now_ms, moisture_a, moisture_b     valid/ready
//  out_ch   out  pump_a_drive, pump_b_drive         valid/ready
//  cfg_ch   in   index, data                        valid/ready (always ready)
//
// One beat per cycle sustained while out_ch accepts results; an input beat is captured
// in the input register, then the pump step writes its result into the result register.
// Pump state updates as an item moves from the input register to the result register.
// A stalled output holds the result register and the input register behind it.
// Synchronous active-low reset clears config, pump state and valid flags.
`timescale 1ns / 1ps
`default_nettype none

module dual_pump_hysteresis_controller_unit (
  input  wire logic  clk,
  input  wire logic  rst_n,
  dphc_in_if.sink    in_ch,
  dphc_out_if.source out_ch,
  dphc_cfg_if.sink   cfg_ch
);

  // config registers
  dphc_pkg::level_t p1_on_r, p1_off_r, p2_on_r, p2_off_r;
  dphc_pkg::tick_t  min_off_r, max_on_r;
  logic             share_r;

  // input register
  logic             s1_valid_r;
  dphc_pkg::tick_t  s1_now_r;
  dphc_pkg::level_t s1_lvl_a_r;
  dphc_pkg::level_t s1_lvl_b_r;

  // pump state and result register
  dphc_pkg::pump_state_t pump_a_r, pump_b_r;
  dphc_pkg::pump_state_t pump_a_nxt, pump_b_nxt;
  logic                  out_valid_r;
  logic                  out_a_r, out_b_r;

  logic             s1_adv;
  logic             in_take;
  dphc_pkg::level_t lvl_1;

  assign s1_adv  = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_take = in_ch.valid && in_ch.ready;

  assign in_ch.ready  = !s1_valid_r || s1_adv;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pump_a_drive = out_a_r;
  assign out_ch.pump_b_drive = out_b_r;

  assign lvl_1 = share_r ? s1_lvl_b_r : s1_lvl_a_r;

  always_comb begin
    pump_a_nxt = dphc_pkg::pump_step(pump_a_r, s1_now_r, lvl_1, p1_on_r, p1_off_r,
                                     min_off_r, max_on_r);
    pump_b_nxt = dphc_pkg::pump_step(pump_b_r, s1_now_r, s1_lvl_b_r, p2_on_r, p2_off_r,
                                     min_off_r, max_on_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_on_r   <= '0;
      p1_off_r  <= '0;
      p2_on_r   <= '0;
      p2_off_r  <= '0;
      min_off_r <= '0;
      max_on_r  <= '0;
      share_r   <= 1'b0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        dphc_pkg::CFG_P1_ON:   p1_on_r   <= cfg_ch.data[dphc_pkg::LevelW-1:0];
        dphc_pkg::CFG_P1_OFF:  p1_off_r  <= cfg_ch.data[dphc_pkg::LevelW-1:0];
        dphc_pkg::CFG_P2_ON:   p2_on_r   <= cfg_ch.data[dphc_pkg::LevelW-1:0];
        dphc_pkg::CFG_P2_OFF:  p2_off_r  <= cfg_ch.data[dphc_pkg::LevelW-1:0];
        dphc_pkg::CFG_MIN_OFF: min_off_r <= cfg_ch.data;
        dphc_pkg::CFG_MAX_ON:  max_on_r  <= cfg_ch.data;
        dphc_pkg::CFG_SHARE:   share_r   <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_now_r   <= in_ch.now_ms;
      s1_lvl_a_r <= in_ch.moisture_a;
      s1_lvl_b_r <= in_ch.moisture_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pump_a_r    <= '0;
      pump_b_r    <= '0;
      out_valid_r <= 1'b0;
      out_a_r     <= 1'b0;
      out_b_r     <= 1'b0;
    end else begin
      if (s1_adv) begin
        pump_a_r <= pump_a_nxt;
        pump_b_r <= pump_b_nxt;
        out_a_r  <= pump_a_nxt.running;
        out_b_r  <= pump_b_nxt.running;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

`include "dual_pump_hysteresis_controller_unit_assert.svh"

  // an item waiting in the input register is not dropped while the output stalls
  `DPHC_ASSERT_NXT(a_s1_hold, s1_valid_r && !s1_adv, s1_valid_r)
  // pump state moves only with an item
  `DPHC_ASSERT_NXT(a_state_quiet, !s1_adv, $stable(pump_a_r) && $stable(pump_b_r))
  // shown result always mirrors the pump state
  `DPHC_ASSERT_NOW(a_out_mirror, out_valid_r,
                   out_a_r == pump_a_r.running && out_b_r == pump_b_r.running)
  // zero max run time never leaves a pump running
  `DPHC_ASSERT_NOW(a_zero_max_on, s1_adv && max_on_r == '0,
                   !pump_a_nxt.running && !pump_b_nxt.running)

endmodule

`default_nettype wire
